// ----- rtl/core/vdu_pkg.sv -----
package vdu_pkg;

	localparam int ELEM_WIDTH_DEF = 16;
	localparam int MAX_DIM_DEF = 1024;

	localparam int ACC_W = 48;
	localparam int MAG_W = ACC_W + 1;
	localparam int ROOT_W = ACC_W / 2;
	localparam int METRIC_W = 3;
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << ACC_W;
	localparam logic [ACC_W-1:0] ONE_Q16 = ACC_W'(65536);

	localparam logic [METRIC_W-1:0] METRIC_SQ_EUCLID = 3'd0;
	localparam logic [METRIC_W-1:0] METRIC_EUCLID = 3'd1;
	localparam logic [METRIC_W-1:0] METRIC_MANHATTAN = 3'd2;
	localparam logic [METRIC_W-1:0] METRIC_DOT = 3'd3;
	localparam logic [METRIC_W-1:0] METRIC_COSINE = 3'd4;

	typedef struct packed {
		logic [ACC_W-1:0] sq_sum;
		logic [ACC_W-1:0] abs_sum;
		logic [ACC_W-1:0] dot_sum;
		logic [ACC_W-1:0] na_sum;
		logic [ACC_W-1:0] nb_sum;
		logic clip;
		logic [METRIC_W-1:0] metric;
	} vdu_snap_t;

	typedef struct packed {
		logic [ACC_W-1:0] val;
		logic clip;
	} vdu_sum_t;

	typedef struct packed {
		logic start;
		logic [ACC_W-1:0] operand;
	} vdu_sqrt_req_t;

	typedef struct packed {
		logic done;
		logic [ROOT_W-1:0] root;
	} vdu_sqrt_rsp_t;

	function automatic vdu_sum_t sat_add(logic [ACC_W-1:0] acc, logic neg,
			logic [MAG_W-1:0] mag);
		logic signed [ACC_W+2:0] acc_x;
		logic signed [ACC_W+2:0] mag_x;
		logic signed [ACC_W+2:0] r;
		vdu_sum_t o;
		acc_x = $signed({{3{acc[ACC_W-1]}}, acc});
		mag_x = $signed({2'b00, mag});
		r = neg ? (acc_x - mag_x) : (acc_x + mag_x);
		if (r[ACC_W+2:ACC_W-1] == '0 || r[ACC_W+2:ACC_W-1] == '1) begin
			o.val = r[ACC_W-1:0];
			o.clip = 1'b0;
		end else if (r[ACC_W+2]) begin
			o.val = {1'b1, {(ACC_W-1){1'b0}}};
			o.clip = 1'b1;
		end else begin
			o.val = {1'b0, {(ACC_W-1){1'b1}}};
			o.clip = 1'b1;
		end
		return o;
	endfunction

endpackage

// ----- rtl/core/vdu_front.sv -----
module vdu_front #(
	parameter int ELEM_WIDTH = vdu_pkg::ELEM_WIDTH_DEF,
	parameter int MAX_DIM = vdu_pkg::MAX_DIM_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic signed [ELEM_WIDTH-1:0] a_elem,
	input logic signed [ELEM_WIDTH-1:0] b_elem,
	input logic last,
	input logic [vdu_pkg::METRIC_W-1:0] metric,
	input logic [vdu_pkg::Q_CNT_W-1:0] q_count,
	output logic snap_push,
	output vdu_pkg::vdu_snap_t snap
);

	localparam int E = ELEM_WIDTH;
	localparam int PW = (2 * E + 2 > vdu_pkg::MAG_W) ? 2 * E + 2 : vdu_pkg::MAG_W;
	localparam int CW = $clog2(MAX_DIM + 1);
	localparam int MW = vdu_pkg::MAG_W;
	localparam int AW = vdu_pkg::ACC_W;

	logic accept;
	logic signed [E:0] a_x, b_x, d_x, an_x, bn_x;
	logic [E:0] dmag, amag, bmag;
	logic [PW-1:0] sq_p, dot_p, na_p, nb_p;
	logic fin;
	logic [CW:0] cnt_inc;

	logic valid_s1, fin_s1, dot_neg_s1;
	logic [MW-1:0] sq_m_s1, abs_m_s1, dot_m_s1, na_m_s1, nb_m_s1;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] sq_q, abs_q, dot_q, na_q, nb_q;
	logic clip_q;

	vdu_pkg::vdu_sum_t sq_n, abs_n, dot_n, na_n, nb_n;
	logic clip_n;

	function automatic logic [MW-1:0] cap(logic [PW-1:0] p);
		if (p > PW'(vdu_pkg::MAG_CAP)) begin
			return vdu_pkg::MAG_CAP;
		end
		return p[MW-1:0];
	endfunction

	assign full = ({1'b0, q_count} + (vdu_pkg::Q_CNT_W+1)'(valid_s1 & fin_s1))
		>= (vdu_pkg::Q_CNT_W+1)'(vdu_pkg::Q_DEPTH);
	assign accept = push && !full;

	always_comb begin
		a_x = {a_elem[E-1], a_elem};
		b_x = {b_elem[E-1], b_elem};
		d_x = a_x - b_x;
		an_x = -a_x;
		bn_x = -b_x;
		dmag = d_x[E] ? $unsigned(-d_x) : $unsigned(d_x);
		amag = a_x[E] ? $unsigned(an_x) : $unsigned(a_x);
		bmag = b_x[E] ? $unsigned(bn_x) : $unsigned(b_x);
		sq_p = PW'(dmag) * PW'(dmag);
		dot_p = PW'(amag) * PW'(bmag);
		na_p = PW'(amag) * PW'(amag);
		nb_p = PW'(bmag) * PW'(bmag);
		cnt_inc = {1'b0, cnt_q} + (CW+1)'(1);
		fin = last || (cnt_inc >= (CW+1)'(MAX_DIM));
	end

	always_comb begin
		sq_n = vdu_pkg::sat_add(sq_q, 1'b0, sq_m_s1);
		abs_n = vdu_pkg::sat_add(abs_q, 1'b0, abs_m_s1);
		dot_n = vdu_pkg::sat_add(dot_q, dot_neg_s1, dot_m_s1);
		na_n = vdu_pkg::sat_add(na_q, 1'b0, na_m_s1);
		nb_n = vdu_pkg::sat_add(nb_q, 1'b0, nb_m_s1);
		clip_n = clip_q | sq_n.clip | abs_n.clip | dot_n.clip | na_n.clip | nb_n.clip;
		snap_push = valid_s1 && fin_s1;
		snap.sq_sum = sq_n.val;
		snap.abs_sum = abs_n.val;
		snap.dot_sum = dot_n.val;
		snap.na_sum = na_n.val;
		snap.nb_sum = nb_n.val;
		snap.clip = clip_n;
		snap.metric = metric;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fin_s1 <= 1'b0;
			cnt_q <= '0;
			sq_q <= '0;
			abs_q <= '0;
			dot_q <= '0;
			na_q <= '0;
			nb_q <= '0;
			clip_q <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				fin_s1 <= fin;
				cnt_q <= fin ? '0 : cnt_inc[CW-1:0];
			end
			if (valid_s1) begin
				if (fin_s1) begin
					sq_q <= '0;
					abs_q <= '0;
					dot_q <= '0;
					na_q <= '0;
					nb_q <= '0;
					clip_q <= 1'b0;
				end else begin
					sq_q <= sq_n.val;
					abs_q <= abs_n.val;
					dot_q <= dot_n.val;
					na_q <= na_n.val;
					nb_q <= nb_n.val;
					clip_q <= clip_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sq_m_s1 <= cap(sq_p);
			abs_m_s1 <= MW'(dmag);
			dot_m_s1 <= cap(dot_p);
			dot_neg_s1 <= a_elem[E-1] ^ b_elem[E-1];
			na_m_s1 <= cap(na_p);
			nb_m_s1 <= cap(nb_p);
		end
	end

endmodule

// ----- rtl/core/vdu_queue.sv -----
module vdu_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input vdu_pkg::vdu_snap_t wr_data,
	input logic rd_en,
	output vdu_pkg::vdu_snap_t rd_data,
	output logic [vdu_pkg::Q_CNT_W-1:0] count
);

	localparam int PTRW = vdu_pkg::Q_PTR_W;

	vdu_pkg::vdu_snap_t mem_q [vdu_pkg::Q_DEPTH];
	logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [vdu_pkg::Q_CNT_W-1:0] count_q;

	function automatic logic [PTRW-1:0] next_ptr(logic [PTRW-1:0] p);
		if (p == PTRW'(vdu_pkg::Q_DEPTH - 1)) begin
			return '0;
		end
		return p + PTRW'(1);
	endfunction

	assign rd_data = mem_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + vdu_pkg::Q_CNT_W'(1);
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - vdu_pkg::Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- rtl/core/vdu_sqrt.sv -----
module vdu_sqrt (
	input logic clk,
	input logic arst_n,
	input vdu_pkg::vdu_sqrt_req_t req,
	output vdu_pkg::vdu_sqrt_rsp_t rsp
);

	localparam int AW = vdu_pkg::ACC_W;

	logic busy_q, done_q;
	logic [AW-1:0] v_q, res_q, bit_q;
	logic [AW:0] trial;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign rsp.done = done_q;
	assign rsp.root = res_q[vdu_pkg::ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q <= req.operand;
			res_q <= '0;
			bit_q <= AW'(1) << (AW - 2);
		end else if (busy_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q <= v_q - trial[AW-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// ----- rtl/core/vdu_back.sv -----
module vdu_back (
	input logic clk,
	input logic arst_n,
	input logic [vdu_pkg::Q_CNT_W-1:0] q_count,
	input vdu_pkg::vdu_snap_t q_data,
	output logic q_pop,
	output logic empty,
	input logic pop,
	output logic signed [vdu_pkg::ACC_W-1:0] distance,
	output logic saturated
);

	localparam int AW = vdu_pkg::ACC_W;
	localparam int RW = vdu_pkg::ROOT_W;
	localparam int NW = AW + 16;
	localparam int DCW = $clog2(NW);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ROOT,
		ST_NA,
		ST_NB,
		ST_MUL,
		ST_DIVSET,
		ST_DIV,
		ST_CLAMP,
		ST_OUT
	} state_t;

	state_t state_q;
	vdu_pkg::vdu_snap_t cur_q;
	vdu_pkg::vdu_sqrt_req_t sq_req_q;
	vdu_pkg::vdu_sqrt_rsp_t sq_rsp;
	logic [RW-1:0] na_root_q, nb_root_q;
	logic [AW-1:0] prod_q, rem_q, res_q;
	logic [NW-1:0] num_q, quo_q;
	logic [DCW-1:0] div_cnt_q;
	logic out_valid_q, saturated_q;
	logic signed [AW-1:0] distance_q;
	logic [AW-1:0] dot_mag;
	logic [AW:0] rem_sh;
	logic [16:0] q_clamp;

	vdu_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.req(sq_req_q),
		.rsp(sq_rsp)
	);

	assign q_pop = (state_q == ST_IDLE) && (q_count != '0);
	assign empty = !out_valid_q;
	assign distance = distance_q;
	assign saturated = saturated_q;

	always_comb begin
		dot_mag = cur_q.dot_sum[AW-1] ? (~cur_q.dot_sum + AW'(1)) : cur_q.dot_sum;
		rem_sh = {rem_q, num_q[NW-1]};
		q_clamp = (quo_q > NW'(65536)) ? 17'd65536 : quo_q[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			sq_req_q.start <= 1'b0;
		end else begin
			sq_req_q.start <= 1'b0;
			if (out_valid_q && pop && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_count != '0) begin
						cur_q <= q_data;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (cur_q.metric)
						vdu_pkg::METRIC_SQ_EUCLID: begin
							res_q <= cur_q.sq_sum;
							state_q <= ST_OUT;
						end
						vdu_pkg::METRIC_EUCLID: begin
							sq_req_q.start <= 1'b1;
							sq_req_q.operand <= cur_q.sq_sum;
							state_q <= ST_ROOT;
						end
						vdu_pkg::METRIC_MANHATTAN: begin
							res_q <= cur_q.abs_sum;
							state_q <= ST_OUT;
						end
						vdu_pkg::METRIC_DOT: begin
							res_q <= cur_q.dot_sum;
							state_q <= ST_OUT;
						end
						vdu_pkg::METRIC_COSINE: begin
							if (cur_q.na_sum[AW-1] || cur_q.na_sum == '0 ||
									cur_q.nb_sum[AW-1] || cur_q.nb_sum == '0) begin
								res_q <= vdu_pkg::ONE_Q16;
								state_q <= ST_OUT;
							end else begin
								sq_req_q.start <= 1'b1;
								sq_req_q.operand <= cur_q.na_sum;
								state_q <= ST_NA;
							end
						end
						default: begin
							res_q <= '0;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_ROOT: begin
					if (sq_rsp.done) begin
						res_q <= AW'(sq_rsp.root);
						state_q <= ST_OUT;
					end
				end
				ST_NA: begin
					if (sq_rsp.done) begin
						na_root_q <= sq_rsp.root;
						sq_req_q.start <= 1'b1;
						sq_req_q.operand <= cur_q.nb_sum;
						state_q <= ST_NB;
					end
				end
				ST_NB: begin
					if (sq_rsp.done) begin
						nb_root_q <= sq_rsp.root;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= AW'(na_root_q) * AW'(nb_root_q);
					state_q <= ST_DIVSET;
				end
				ST_DIVSET: begin
					if (prod_q == '0) begin
						res_q <= vdu_pkg::ONE_Q16;
						state_q <= ST_OUT;
					end else begin
						num_q <= {dot_mag, 16'h0000};
						rem_q <= '0;
						quo_q <= '0;
						div_cnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					num_q <= num_q << 1;
					if (rem_sh >= {1'b0, prod_q}) begin
						rem_q <= AW'(rem_sh - {1'b0, prod_q});
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[AW-1:0];
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DCW'(NW - 1)) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					if (cur_q.dot_sum[AW-1]) begin
						res_q <= vdu_pkg::ONE_Q16 + AW'(q_clamp);
					end else begin
						res_q <= vdu_pkg::ONE_Q16 - AW'(q_clamp);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || pop) begin
						out_valid_q <= 1'b1;
						distance_q <= $signed(res_q);
						saturated_q <= cur_q.clip;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/vector_distance_unit.sv -----
// Element pairs enter one per cycle while full is low; the front end multiplies and
// accumulates them with saturation, and each final pair hands a snapshot of the sums to a
// two-entry queue. The back end turns each snapshot into one result: the squared
// Euclidean, Manhattan and dot product metrics pass a sum through, Euclidean distance
// takes one iterative square root of two bits per cycle, and cosine distance takes two
// square roots, a multiply and a restoring divider; the other metric codes give zero.
// Short vectors stall at full when snapshots arrive faster than the back end can finish.
module vector_distance_unit #(
	parameter int ELEM_WIDTH = vdu_pkg::ELEM_WIDTH_DEF,
	parameter int MAX_DIM = vdu_pkg::MAX_DIM_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic signed [ELEM_WIDTH-1:0] a_elem,
	input logic signed [ELEM_WIDTH-1:0] b_elem,
	input logic last,
	output logic empty,
	input logic pop,
	output logic signed [vdu_pkg::ACC_W-1:0] distance,
	output logic saturated,
	input logic cfg_we,
	input logic [vdu_pkg::METRIC_W-1:0] cfg_wdata
);

	logic [vdu_pkg::METRIC_W-1:0] metric_q;
	logic snap_push, q_pop;
	vdu_pkg::vdu_snap_t snap, q_data;
	logic [vdu_pkg::Q_CNT_W-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= vdu_pkg::METRIC_SQ_EUCLID;
		end else if (cfg_we) begin
			metric_q <= cfg_wdata;
		end
	end

	vdu_front #(
		.ELEM_WIDTH(ELEM_WIDTH),
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.a_elem(a_elem),
		.b_elem(b_elem),
		.last(last),
		.metric(metric_q),
		.q_count(q_count),
		.snap_push(snap_push),
		.snap(snap)
	);

	vdu_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(snap_push),
		.wr_data(snap),
		.rd_en(q_pop),
		.rd_data(q_data),
		.count(q_count)
	);

	vdu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_count(q_count),
		.q_data(q_data),
		.q_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.distance(distance),
		.saturated(saturated)
	);

endmodule

// ----- verif/tb.sv -----
module tb;

	localparam logic [vdu_pkg::METRIC_W-1:0] METRIC_SPARE_LO = 3'd5;
	localparam logic [vdu_pkg::METRIC_W-1:0] METRIC_SPARE_MID = 3'd6;
	localparam logic [vdu_pkg::METRIC_W-1:0] METRIC_SPARE_HI = 3'd7;
	localparam int DIM_LIMIT = vdu_pkg::MAX_DIM_DEF;
	localparam int SETTLE_CYCLES = 160;
	localparam int IDLE_LIMIT = 4000;
	localparam longint SUM_MAX = 64'sh00007FFFFFFFFFFF;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam longint ONE_Q16_L = 65536;

	typedef struct {
		logic [vdu_pkg::ACC_W-1:0] dval;
		logic sat;
	} dist_result_t;

	typedef struct {
		bit wr;
		logic [vdu_pkg::METRIC_W-1:0] m;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic l;
		bit known;
		longint dval;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [15:0] a_elem = '0;
	logic signed [15:0] b_elem = '0;
	logic last = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [vdu_pkg::ACC_W-1:0] distance;
	logic saturated;
	logic cfg_we = 1'b0;
	logic [vdu_pkg::METRIC_W-1:0] cfg_wdata = '0;

	vector_distance_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.a_elem(a_elem),
		.b_elem(b_elem),
		.last(last),
		.empty(empty),
		.pop(pop),
		.distance(distance),
		.saturated(saturated),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	logic [vdu_pkg::METRIC_W-1:0] cur_metric = vdu_pkg::METRIC_SQ_EUCLID;
	longint sq_acc = 0, abs_acc = 0, dot_acc = 0, na_acc = 0, nb_acc = 0;
	bit clip_seen = 0;
	int pairs_seen = 0;
	dist_result_t expected_q[$];
	longint pinned_q[$];
	bit pinned_flag_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit hold_req = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint sat_acc(longint acc, bit neg, longint mag);
		longint r;
		r = neg ? acc - mag : acc + mag;
		if (r > SUM_MAX) begin
			clip_seen = 1;
			return SUM_MAX;
		end
		if (r < SUM_MIN) begin
			clip_seen = 1;
			return SUM_MIN;
		end
		return r;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint cosine_dist();
		longint unsigned na, nb, prod, num, q;
		if (na_acc <= 0 || nb_acc <= 0)
			return ONE_Q16_L;
		na = int_sqrt(na_acc);
		nb = int_sqrt(nb_acc);
		prod = na * nb;
		if (prod == 0)
			return ONE_Q16_L;
		num = (dot_acc < 0 ? -dot_acc : dot_acc) << 16;
		q = num / prod;
		if (q > ONE_Q16_L)
			q = ONE_Q16_L;
		return dot_acc < 0 ? ONE_Q16_L + longint'(q) : ONE_Q16_L - longint'(q);
	endfunction

	task automatic accumulate_pair(longint a, longint b, bit fin);
		longint d, am, bm, dm, dist_v, pin_val;
		bit pin;
		dist_result_t res;
		d = a - b;
		dm = d < 0 ? -d : d;
		am = a < 0 ? -a : a;
		bm = b < 0 ? -b : b;
		sq_acc = sat_acc(sq_acc, 0, (dm >= (64'd1 << 24)) ? (64'd1 << 48) : dm * dm);
		abs_acc = sat_acc(abs_acc, 0, dm);
		dot_acc = sat_acc(dot_acc, (a < 0) != (b < 0), am * bm);
		na_acc = sat_acc(na_acc, 0, am * am);
		nb_acc = sat_acc(nb_acc, 0, bm * bm);
		pairs_seen++;
		if (pairs_seen >= DIM_LIMIT)
			fin = 1;
		if (!fin)
			return;
		case (cur_metric)
			vdu_pkg::METRIC_SQ_EUCLID: dist_v = sq_acc;
			vdu_pkg::METRIC_EUCLID: dist_v = int_sqrt(sq_acc);
			vdu_pkg::METRIC_MANHATTAN: dist_v = abs_acc;
			vdu_pkg::METRIC_DOT: dist_v = dot_acc;
			vdu_pkg::METRIC_COSINE: dist_v = cosine_dist();
			default: dist_v = 0;
		endcase
		if (pinned_flag_q.size() != 0) begin
			pin = pinned_flag_q.pop_front();
			pin_val = pinned_q.pop_front();
			if (pin)
				dist_v = pin_val;
		end
		res.dval = dist_v[vdu_pkg::ACC_W-1:0];
		res.sat = clip_seen;
		expected_q.push_back(res);
		sq_acc = 0;
		abs_acc = 0;
		dot_acc = 0;
		na_acc = 0;
		nb_acc = 0;
		clip_seen = 0;
		pairs_seen = 0;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	always @(posedge clk) begin
		dist_result_t want;
		bit moved;
		moved = 0;
		if (arst_n && cfg_we)
			cur_metric <= cfg_wdata;
		if (arst_n && push && !full) begin
			accumulate_pair(a_elem, b_elem, last);
			moved = 1;
		end
		if (arst_n && pop && !empty) begin
			moved = 1;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected transaction distance", distance, 0);
			end else begin
				want = expected_q.pop_front();
				if (distance !== want.dval)
					report_mismatch("distance", $signed(distance), $signed(want.dval));
				if (saturated !== want.sat)
					report_mismatch("saturated", saturated, want.sat);
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int mode, span;
		mode = 0;
		span = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 300);
			end
			span--;
			case (mode)
				0: pop <= 1'b1;
				1: pop <= $urandom_range(0, 1);
				2: pop <= ($urandom_range(0, 7) == 0);
				default: pop <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic l);
		int g;
		if (burst_left == 0) begin
			g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (g != 0) begin
				push <= 1'b0;
				repeat (g) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		push <= 1'b1;
		a_elem <= a;
		b_elem <= b;
		last <= l;
		@(posedge clk);
		while (full)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic drain_results();
		push <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_metric(logic [vdu_pkg::METRIC_W-1:0] m);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [15:0] pick_elem();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1: return $signed(16'($urandom_range(0, 16)) - 16'sd8);
			2: return 16'sd0;
			default: return $signed(16'($urandom()));
		endcase
	endfunction

	stim_row_t dir_rows[] = '{
		'{1, vdu_pkg::METRIC_SQ_EUCLID, 0, 0, 0, 0, 0},
		'{0, 0, 16'sd0, 16'sd0, 1, 1, 0},
		'{0, 0, 16'sh7FFF, 16'sh8000, 1, 1, 64'd4294836225},
		'{0, 0, 16'sh8000, 16'sh7FFF, 0, 0, 0},
		'{0, 0, 16'sh8000, 16'sh7FFF, 1, 0, 0},
		'{0, 0, 16'sh8000, 16'sh8000, 1, 1, 0},
		'{1, vdu_pkg::METRIC_EUCLID, 0, 0, 0, 0, 0},
		'{0, 0, 16'sd256, 16'sd0, 1, 1, 256},
		'{0, 0, 16'sd1, 16'sd2, 0, 0, 0},
		'{0, 0, 16'sd3, -16'sd4, 1, 0, 0},
		'{1, vdu_pkg::METRIC_MANHATTAN, 0, 0, 0, 0, 0},
		'{0, 0, 16'sh8000, 16'sh7FFF, 1, 1, 65535},
		'{0, 0, 16'sd5, 16'sd7, 1, 0, 0},
		'{1, vdu_pkg::METRIC_DOT, 0, 0, 0, 0, 0},
		'{0, 0, 16'sh8000, 16'sh7FFF, 1, 1, -64'sd1073709056},
		'{0, 0, 16'sh8000, 16'sh8000, 1, 1, 64'sd1073741824},
		'{1, vdu_pkg::METRIC_COSINE, 0, 0, 0, 0, 0},
		'{0, 0, 16'sd0, 16'sd5, 1, 1, 65536},
		'{0, 0, 16'sd0, 16'sd0, 1, 1, 65536},
		'{0, 0, 16'sd256, 16'sd256, 1, 1, 0},
		'{0, 0, 16'sd256, -16'sd256, 1, 1, 131072},
		'{0, 0, 16'sd100, 16'sd37, 0, 0, 0},
		'{0, 0, -16'sd9, 16'sd200, 1, 0, 0},
		'{1, METRIC_SPARE_HI, 0, 0, 0, 0, 0},
		'{0, 0, 16'sd1, 16'sd1, 1, 1, 0},
		'{1, METRIC_SPARE_LO, 0, 0, 0, 0, 0},
		'{0, 0, 16'sd2, 16'sd3, 1, 1, 0}
	};

	logic [vdu_pkg::METRIC_W-1:0] phase_metric[] = '{
		vdu_pkg::METRIC_MANHATTAN, vdu_pkg::METRIC_SQ_EUCLID, vdu_pkg::METRIC_EUCLID,
		vdu_pkg::METRIC_DOT, vdu_pkg::METRIC_COSINE, METRIC_SPARE_LO, METRIC_SPARE_MID,
		METRIC_SPARE_HI, vdu_pkg::METRIC_COSINE, vdu_pkg::METRIC_EUCLID,
		vdu_pkg::METRIC_SQ_EUCLID, vdu_pkg::METRIC_DOT, vdu_pkg::METRIC_MANHATTAN,
		vdu_pkg::METRIC_COSINE
	};

	initial begin
		int len, sent;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].wr) begin
				write_metric(dir_rows[i].m);
			end else begin
				if (dir_rows[i].l) begin
					pinned_flag_q.push_back(dir_rows[i].known);
					pinned_q.push_back(dir_rows[i].dval);
				end
				send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].l);
			end
		end
		foreach (phase_metric[p]) begin
			write_metric(phase_metric[p]);
			if (p == 0) begin
				for (int k = 0; k < DIM_LIMIT; k++)
					send_pair(pick_elem(), pick_elem(), 1'b0);
				hold_req = 1;
			end
			sent = 0;
			while (sent < 45) begin
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 30)
					: $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					send_pair(pick_elem(), pick_elem(), k == len - 1);
				sent += len;
			end
		end
		drain_results();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- vector_distance_unit.f -----
rtl/core/vdu_pkg.sv
rtl/core/vdu_front.sv
rtl/core/vdu_queue.sv
rtl/core/vdu_sqrt.sv
rtl/core/vdu_back.sv
rtl/core/vector_distance_unit.sv
verif/tb.sv
